// File: design/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types, widths and constants for the RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

   // Field widths of the pixel and result channels
   localparam int CHAN_W = 8;
   localparam int HUE_W  = 15;
   localparam int SAT_W  = 13;

   // Fixed-point fraction bits of hue and saturation
   localparam int HUE_FRAC_BITS = 6;
   localparam int SAT_FRAC_BITS = 12;

   // Hue numerator base*delta + 60*num is below 360*255, so 17 bits hold it
   localparam int HUE_NUM_W = 17;
   localparam int HUE_DVD_W = HUE_NUM_W + HUE_FRAC_BITS + 1;
   localparam int SAT_DVD_W = CHAN_W + SAT_FRAC_BITS + 1;
   localparam int DVS_W     = CHAN_W + 1;

   // Quotient widths; both dividers share the larger one so latencies match
   localparam int HUE_FULL_TURN = 360 << HUE_FRAC_BITS;
   localparam int HUE_Q_W = $clog2(HUE_FULL_TURN + 1);
   localparam int SAT_Q_W = SAT_FRAC_BITS + 1;
   localparam int DIV_Q_W = (HUE_Q_W > SAT_Q_W) ? HUE_Q_W : SAT_Q_W;

   // Hue sector angles in whole degrees
   localparam int SECTOR_ANG_W = 9;
   localparam logic [SECTOR_ANG_W-1:0] ANG_RED_WRAP = SECTOR_ANG_W'(360);
   localparam logic [SECTOR_ANG_W-1:0] ANG_RED      = SECTOR_ANG_W'(0);
   localparam logic [SECTOR_ANG_W-1:0] ANG_GREEN    = SECTOR_ANG_W'(120);
   localparam logic [SECTOR_ANG_W-1:0] ANG_BLUE     = SECTOR_ANG_W'(240);

   // Channel that holds the maximum
   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   // Divider operands produced by the front stages
   typedef struct packed {
      logic [HUE_DVD_W-1:0] hue_dvd;
      logic [DVS_W-1:0]     hue_dvs;
      logic                 hue_zero;
      logic [SAT_DVD_W-1:0] sat_dvd;
      logic [DVS_W-1:0]     sat_dvs;
      logic                 sat_zero;
      logic [CHAN_W-1:0]    value;
   } prep_out_type;

endpackage

// File: design/rgbhsv_ifs.sv
// ----------------------------------------------------------------------------
// rgbhsv_ifs
// Valid/ready channels for the pixel input and the HSV result.
// ----------------------------------------------------------------------------
interface rgbhsv_req_if;
   import rgbhsv_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsv_rsp_if;
   import rgbhsv_pkg::*;

   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue;
   logic [SAT_W-1:0]  saturation;
   logic [CHAN_W-1:0] brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

// File: design/rgbhsv_prep.sv
// ----------------------------------------------------------------------------
// rgbhsv_prep
// Two pipeline stages: find max, min and hue sector, then build the
// dividends and divisors for hue and saturation.
// ----------------------------------------------------------------------------
module rgbhsv_prep
   import rgbhsv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [CHAN_W-1:0] red,
   input  logic [CHAN_W-1:0] green,
   input  logic [CHAN_W-1:0] blue,
   output logic              out_valid,
   output prep_out_type      out_op
);

   // Stage A signals
   logic [CHAN_W-1:0]        mx_in, mn_in;
   sector_type               sector_in;
   logic signed [CHAN_W:0]   num_in;

   logic                     a_valid_ff;
   logic [CHAN_W-1:0]        a_mx_ff, a_delta_ff;
   logic signed [CHAN_W:0]   a_num_ff;
   sector_type               a_sector_ff;

   // Stage B signals
   logic [SECTOR_ANG_W-1:0]       base;
   logic signed [HUE_NUM_W:0]     base_prod, num_x, num_prod, top_sum;
   prep_out_type                  op_in;

   logic                          b_valid_ff;
   prep_out_type                  b_op_ff;

   // Pick max, min and sector; red wins ties, then green
   always_comb begin
      mx_in = red;
      if (green > mx_in) mx_in = green;
      if (blue > mx_in) mx_in = blue;
      mn_in = red;
      if (green < mn_in) mn_in = green;
      if (blue < mn_in) mn_in = blue;

      priority if (mx_in == red) begin
         sector_in = SECTOR_RED;
         num_in    = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (mx_in == green) begin
         sector_in = SECTOR_GREEN;
         num_in    = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         sector_in = SECTOR_BLUE;
         num_in    = $signed({1'b0, red}) - $signed({1'b0, green});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_mx_ff     <= mx_in;
         a_delta_ff  <= mx_in - mn_in;
         a_num_ff    <= num_in;
         a_sector_ff <= sector_in;
      end
   end

   // Build base*delta + 60*num and the rounding dividends
   always_comb begin
      unique case (a_sector_ff)
         SECTOR_RED:   base = a_num_ff[CHAN_W] ? ANG_RED_WRAP : ANG_RED;
         SECTOR_GREEN: base = ANG_GREEN;
         SECTOR_BLUE:  base = ANG_BLUE;
         default:      base = ANG_RED;
      endcase

      base_prod = $signed((HUE_NUM_W+1)'(base) * (HUE_NUM_W+1)'(a_delta_ff));
      num_x     = (HUE_NUM_W+1)'(a_num_ff);
      num_prod  = (num_x <<< 6) - (num_x <<< 2);
      top_sum   = base_prod + num_prod;

      op_in.hue_dvd  = HUE_DVD_W'({top_sum[HUE_NUM_W-1:0], {(HUE_FRAC_BITS+1){1'b0}}})
                     + HUE_DVD_W'(a_delta_ff);
      op_in.hue_dvs  = {a_delta_ff, 1'b0};
      op_in.hue_zero = (a_delta_ff == '0);
      op_in.sat_dvd  = SAT_DVD_W'({a_delta_ff, {(SAT_FRAC_BITS+1){1'b0}}})
                     + SAT_DVD_W'(a_mx_ff);
      op_in.sat_dvs  = {a_mx_ff, 1'b0};
      op_in.sat_zero = (a_mx_ff == '0);
      op_in.value    = a_mx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_op_ff <= op_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_op    = b_op_ff;

endmodule

// File: design/rgbhsv_div.sv
// ----------------------------------------------------------------------------
// rgbhsv_div
// Pipelined restoring divider: one quotient bit per stage, Q_W stages.
// The quotient must fit Q_W bits; side data travels with each item.
// ----------------------------------------------------------------------------
module rgbhsv_div
   import rgbhsv_pkg::*;
#(
   parameter int DVD_W  = HUE_DVD_W,
   parameter int DVS_W  = rgbhsv_pkg::DVS_W,
   parameter int Q_W    = DIV_Q_W,
   parameter int SIDE_W = 1
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [DVD_W-1:0]  in_dvd,
   input  logic [DVS_W-1:0]  in_dvs,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [Q_W-1:0]    out_quot,
   output logic [SIDE_W-1:0] out_side
);

   // Per-stage registers
   logic              valid_ff [Q_W];
   logic [DVS_W-1:0]  rem_ff   [Q_W];
   logic [Q_W-1:0]    word_ff  [Q_W];
   logic [DVS_W-1:0]  dvs_ff   [Q_W];
   logic [SIDE_W-1:0] side_ff  [Q_W];

   // Stage inputs and next values
   logic              src_valid [Q_W];
   logic [DVS_W-1:0]  src_rem   [Q_W];
   logic [Q_W-1:0]    src_word  [Q_W];
   logic [DVS_W-1:0]  src_dvs   [Q_W];
   logic [SIDE_W-1:0] src_side  [Q_W];
   logic [DVS_W:0]    trial     [Q_W];
   logic              take      [Q_W];
   logic [DVS_W-1:0]  rem_in    [Q_W];
   logic [Q_W-1:0]    word_in   [Q_W];

   // Feed each stage from the previous one; the top dividend bits seed stage 0
   always_comb begin
      for (int k = 0; k < Q_W; k++) begin
         if (k == 0) begin
            src_valid[k] = in_valid;
            src_rem[k]   = DVS_W'(in_dvd >> Q_W);
            src_word[k]  = in_dvd[Q_W-1:0];
            src_dvs[k]   = in_dvs;
            src_side[k]  = in_side;
         end else begin
            src_valid[k] = valid_ff[k-1];
            src_rem[k]   = rem_ff[k-1];
            src_word[k]  = word_ff[k-1];
            src_dvs[k]   = dvs_ff[k-1];
            src_side[k]  = side_ff[k-1];
         end
      end
   end

   // Shift in one dividend bit, subtract when it fits, shift the quotient bit in
   always_comb begin
      for (int k = 0; k < Q_W; k++) begin
         trial[k]   = {src_rem[k], src_word[k][Q_W-1]};
         take[k]    = (trial[k] >= {1'b0, src_dvs[k]});
         rem_in[k]  = take[k] ? DVS_W'(trial[k] - {1'b0, src_dvs[k]}) : DVS_W'(trial[k]);
         word_in[k] = {src_word[k][Q_W-2:0], take[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Q_W; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < Q_W; k++) valid_ff[k] <= src_valid[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < Q_W; k++) begin
            rem_ff[k]  <= rem_in[k];
            word_ff[k] <= word_in[k];
            dvs_ff[k]  <= src_dvs[k];
            side_ff[k] <= src_side[k];
         end
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_quot  = word_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

// File: design/rgb_to_hsv_pixel_top.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_top
// Converts a stream of 8-bit RGB pixels to fixed-point HSV, one per clock while rsp is taken.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one pixel (red, green, blue) per transfer; rsp carries the
//   matching hue (degrees x 64), saturation (x 4096) and brightness (max
//   channel). Every pixel gives exactly one result, in order.
// Pipeline: a req transfer reaches rsp valid through two front stages
//   (max/min/sector, then operand build), 15 divider stages (one quotient bit
//   each, hue and saturation dividers in parallel) and the output register.
// Throughput: one pixel per clock while rsp is taken.
// Stall: the whole pipeline holds while the output register is full and
//   rsp.ready is low; req.ready drops in the same cycle, so nothing is lost
//   or repeated. Empty slots still advance while the output is free.
// Reset: synchronous, active high; clears all valid bits and holds req.ready
//   low, the block keeps no other state.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_top
   import rgbhsv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   rgbhsv_req_if.sink    req,
   rgbhsv_rsp_if.source  rsp
);

   localparam int HUE_SIDE_W = CHAN_W + 1;

   logic                     en;
   logic                     prep_valid;
   prep_out_type             prep_op;

   logic                     hue_valid, sat_valid;
   logic [DIV_Q_W-1:0]       hue_quot, sat_quot;
   logic [HUE_SIDE_W-1:0]    hue_side;
   logic [0:0]               sat_side;

   logic [DIV_Q_W-1:0]       hue_wrap;
   logic [HUE_W-1:0]         hue_in;
   logic [SAT_W-1:0]         sat_in;

   logic                     rsp_valid_ff;
   logic [HUE_W-1:0]         hue_ff;
   logic [SAT_W-1:0]         sat_ff;
   logic [CHAN_W-1:0]        value_ff;

   // Advance everything unless a result waits on a stalled receiver
   assign en        = !rsp_valid_ff || rsp.ready;
   // Take no transfer while reset is high
   assign req.ready = en && !reset;

   rgbhsv_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req.valid),
      .red       (req.red),
      .green     (req.green),
      .blue      (req.blue),
      .out_valid (prep_valid),
      .out_op    (prep_op)
   );

   rgbhsv_div #(
      .DVD_W  (HUE_DVD_W),
      .DVS_W  (DVS_W),
      .Q_W    (DIV_Q_W),
      .SIDE_W (HUE_SIDE_W)
   ) u_hue_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prep_valid),
      .in_dvd    (prep_op.hue_dvd),
      .in_dvs    (prep_op.hue_dvs),
      .in_side   ({prep_op.hue_zero, prep_op.value}),
      .out_valid (hue_valid),
      .out_quot  (hue_quot),
      .out_side  (hue_side)
   );

   rgbhsv_div #(
      .DVD_W  (SAT_DVD_W),
      .DVS_W  (DVS_W),
      .Q_W    (DIV_Q_W),
      .SIDE_W (1)
   ) u_sat_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prep_valid),
      .in_dvd    (prep_op.sat_dvd),
      .in_dvs    (prep_op.sat_dvs),
      .in_side   (prep_op.sat_zero),
      .out_valid (sat_valid),
      .out_quot  (sat_quot),
      .out_side  (sat_side)
   );

   // Wrap a rounded full turn to zero; force gray and black cases
   always_comb begin
      if (hue_quot >= DIV_Q_W'(HUE_FULL_TURN)) begin
         hue_wrap = hue_quot - DIV_Q_W'(HUE_FULL_TURN);
      end else begin
         hue_wrap = hue_quot;
      end
      hue_in = hue_side[CHAN_W] ? '0 : HUE_W'(hue_wrap);
      sat_in = sat_side[0]      ? '0 : SAT_W'(sat_quot);
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= hue_valid && sat_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         value_ff <= hue_side[CHAN_W-1:0];
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.hue        = hue_ff;
   assign rsp.saturation = sat_ff;
   assign rsp.brightness = value_ff;

endmodule

// File: dv/rgb_to_hsv_pixel_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_top_tb
// Self-checking bench for the RGB to HSV pixel pipeline. Pixels go in through
// the req channel in bursts with random gaps. An in-bench model works out
// hue, saturation and brightness for each accepted pixel and queues them in
// order. Each rsp transfer is compared field by field with the oldest queued
// result while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_top_tb;
   import rgbhsv_pkg::*;

   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [SAT_W-1:0]  saturation;
      logic [CHAN_W-1:0] brightness;
   } hsv_type;

   logic clock;
   logic reset;

   rgbhsv_req_if req_ch ();
   rgbhsv_rsp_if rsp_ch ();

   rgb_to_hsv_pixel_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   hsv_type hsv_pending[$];
   int      mismatch_count;
   int      idle_cycles;
   bit      sender_gaps;
   bit      receiver_stalls;
   int      burst_left;

   // Clock: 1 ns high, 1 ns low
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Expected HSV of one pixel, rounded half up as the pipeline does
   function automatic hsv_type convert_pixel(input logic [CHAN_W-1:0] r,
                                             input logic [CHAN_W-1:0] g,
                                             input logic [CHAN_W-1:0] b);
      hsv_type    res;
      sector_type sector;
      int         mx;
      int         mn;
      int         delta;
      int         num;
      longint     base;
      longint     top;
      longint     h;
      longint     s;
      mx = r;
      sector = SECTOR_RED;
      if (g > mx) begin
         mx = g;
         sector = SECTOR_GREEN;
      end
      if (b > mx) begin
         mx = b;
         sector = SECTOR_BLUE;
      end
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;
      h = 0;
      s = 0;
      if (delta != 0) begin
         case (sector)
            SECTOR_RED: begin
               num = int'(g) - int'(b);
               base = (num < 0) ? longint'(ANG_RED_WRAP) : longint'(ANG_RED);
            end
            SECTOR_GREEN: begin
               num = int'(b) - int'(r);
               base = ANG_GREEN;
            end
            default: begin
               num = int'(r) - int'(g);
               base = ANG_BLUE;
            end
         endcase
         top = base * delta + 60 * num;
         h = ((top <<< (HUE_FRAC_BITS + 1)) + delta) / (2 * delta);
         // rounding up to a full turn wraps back to zero
         if (h >= HUE_FULL_TURN) h = h - HUE_FULL_TURN;
      end
      if (mx != 0) begin
         s = ((longint'(delta) <<< (SAT_FRAC_BITS + 1)) + mx) / (2 * mx);
      end
      res.hue        = h[HUE_W-1:0];
      res.saturation = s[SAT_W-1:0];
      res.brightness = mx[CHAN_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Queue the expected result of each pixel transfer
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         hsv_pending.push_back(convert_pixel(req_ch.red, req_ch.green, req_ch.blue));
      end
   end

   // Check each result transfer against the oldest expectation
   always @(posedge clock) begin
      hsv_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (hsv_pending.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = hsv_pending.pop_front();
            if (rsp_ch.hue !== want.hue)
               report_mismatch("hue", rsp_ch.hue, want.hue);
            if (rsp_ch.saturation !== want.saturation)
               report_mismatch("saturation", rsp_ch.saturation, want.saturation);
            if (rsp_ch.brightness !== want.brightness)
               report_mismatch("brightness", rsp_ch.brightness, want.brightness);
         end
      end
   end

   // Receiver: fresh 16-bit ready mask per window, sometimes a fully stalled window
   initial begin
      logic [15:0] mask;
      int          phase;
      rsp_ch.ready <= 1'b0;
      mask = '1;
      phase = 0;
      forever begin
         @(posedge clock);
         if (phase == 0) begin
            mask = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom);
         end
         rsp_ch.ready <= receiver_stalls ? mask[phase] : 1'b1;
         phase = (phase + 1) % 16;
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("rgb_to_hsv_pixel_top regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Drive one pixel and hold it until the transfer; called right after an edge
   task automatic send_pixel(input logic [CHAN_W-1:0] r,
                             input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b);
      int gap;
      if (sender_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.red   <= r;
      req_ch.green <= g;
      req_ch.blue  <= b;
      @(posedge clock iff (req_ch.ready === 1'b1));
      if (burst_left > 0) burst_left--;
   endtask

   // Extremes, each max channel, ties and the near-wrap red hues
   task automatic test_directed();
      send_pixel(8'd0,   8'd0,   8'd0);     // black
      send_pixel(8'd255, 8'd255, 8'd255);   // white
      send_pixel(8'd128, 8'd128, 8'd128);   // mid gray
      send_pixel(8'd1,   8'd1,   8'd1);
      send_pixel(8'd255, 8'd0,   8'd0);     // pure primaries
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);     // red and green tie, red wins
      send_pixel(8'd0,   8'd255, 8'd255);   // green and blue tie, green wins
      send_pixel(8'd255, 8'd0,   8'd255);   // red and blue tie, red wins
      send_pixel(8'd255, 8'd0,   8'd1);     // red sector, negative numerator
      send_pixel(8'd255, 8'd254, 8'd255);
      send_pixel(8'd255, 8'd1,   8'd0);
      send_pixel(8'd1,   8'd0,   8'd0);     // smallest nonzero channels
      send_pixel(8'd0,   8'd1,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd255, 8'd254, 8'd254);   // delta of one at full scale
      send_pixel(8'd255, 8'd128, 8'd0);
      send_pixel(8'd85,  8'd170, 8'd255);
      send_pixel(8'd170, 8'd85,  8'd255);
      send_pixel(8'd200, 8'd10,  8'd100);
      send_pixel(8'd3,   8'd7,   8'd5);
   endtask

   // Uniform random pixels
   task automatic test_random_pixels(input int count);
      repeat (count) begin
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   // Ties, grays, tiny deltas and rails
   task automatic test_corner_pixels(input int count);
      logic [CHAN_W-1:0] a;
      logic [CHAN_W-1:0] c;
      logic [CHAN_W-1:0] ch[3];
      repeat (count) begin
         a = 8'($urandom);
         c = 8'($urandom);
         case ($urandom_range(0, 4))
            0: begin
               ch[0] = a; ch[1] = a; ch[2] = a;
            end
            1: begin
               ch[0] = a; ch[1] = a; ch[2] = c;
            end
            2: begin
               ch[0] = a; ch[1] = 8'(a - $urandom_range(0, 2)); ch[2] = 8'(a + 1);
            end
            3: begin
               ch[0] = 8'd255; ch[1] = 8'd0; ch[2] = c;
            end
            default: begin
               ch[0] = a; ch[1] = c; ch[2] = c;
            end
         endcase
         // rotate so every channel takes every role
         case ($urandom_range(0, 2))
            0: send_pixel(ch[0], ch[1], ch[2]);
            1: send_pixel(ch[2], ch[0], ch[1]);
            default: send_pixel(ch[1], ch[2], ch[0]);
         endcase
      end
   endtask

   // Full rate on both sides
   task automatic test_back_to_back(input int count);
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      test_random_pixels(count);
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   initial begin
      mismatch_count = 0;
      idle_cycles = 0;
      burst_left = 0;
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.red   <= '0;
      req_ch.green <= '0;
      req_ch.blue  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_pixels(700);
      test_back_to_back(200);
      test_corner_pixels(400);
      test_random_pixels(200);
      req_ch.valid <= 1'b0;

      // Drain: wait for outstanding results, then let the pipe settle
      while (hsv_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("rgb_to_hsv_pixel_top regression: pass");
      end else begin
         $display("rgb_to_hsv_pixel_top regression: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
design/rgbhsv_pkg.sv
design/rgbhsv_ifs.sv
design/rgbhsv_prep.sv
design/rgbhsv_div.sv
design/rgb_to_hsv_pixel_top.sv
dv/rgb_to_hsv_pixel_top_tb.sv
